FILE: hw/rtl/ntp_pkg.sv
// ntp_pkg: shared constants, codes and types for the nested task time profiler
// used by ntp_divider, nested_task_time_profiler_unit and the testbench; no dependencies
`default_nettype none

package ntp_pkg;

   // sizes
   localparam int NUM_TASKS   = 4;
   localparam int STACK_DEPTH = 16;
   localparam int TASK_W      = 2;
   localparam int DATA_W      = 32;
   localparam int SCALE_W     = 20;
   localparam int PROD_W      = DATA_W + SCALE_W;
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int ITER_W      = $clog2(DATA_W);
   localparam int CMP_W       = TASK_W + 4;

   // parts per million scale for load reads
   localparam logic [SCALE_W-1:0] PPM_SCALE = SCALE_W'(1000000);

   // request codes
   typedef enum logic [2:0] {
      REQ_BEGIN        = 3'd0,
      REQ_END          = 3'd1,
      REQ_TICK         = 3'd2,
      REQ_READ_LOAD    = 3'd3,
      REQ_READ_MAX     = 3'd4,
      REQ_READ_ONGOING = 3'd5
   } req_code_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK           = 2'd0,
      STAT_OVERFLOW     = 2'd1,
      STAT_UNDERFLOW    = 2'd2,
      STAT_ZERO_ELAPSED = 2'd3
   } status_type;

   // sequencer states of the top level
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_CHG_DIFF,
      S_CHG_ADD,
      S_PUSH,
      S_END_LOOP,
      S_END_RESTART,
      S_ONG_SUM,
      S_MAX_RD,
      S_LOAD_CALC,
      S_LOAD_CHECK,
      S_LOAD_WAIT,
      S_TICK,
      S_RESP
   } top_state_type;

   // divider states
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ntp_divider.sv
// ntp_divider: iterative restoring divider, one quotient bit per cycle,
// saturating to all ones when the quotient exceeds 32 bits; uses ntp_pkg
`default_nettype none

module ntp_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ntp_pkg::div_req_type div_req,
   output ntp_pkg::div_rsp_type     div_rsp
);

   ntp_pkg::div_state_type state_ff, state_in;

   logic [ntp_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic [ntp_pkg::DATA_W-1:0] quo_ff, quo_in;
   logic [ntp_pkg::DATA_W-1:0] divisor_ff, divisor_in;
   logic [ntp_pkg::ITER_W-1:0] iter_ff, iter_in;

   logic [ntp_pkg::DATA_W-1:0] high_part;
   logic                       saturate;
   logic [ntp_pkg::DATA_W:0]   trial;
   logic                       last_iter;

   // upper dividend bits decide saturation before any iteration
   assign high_part = ntp_pkg::DATA_W'(div_req.dividend[ntp_pkg::PROD_W-1:ntp_pkg::DATA_W]);
   assign saturate  = (high_part >= div_req.divisor);
   assign trial     = {rem_ff, quo_ff[ntp_pkg::DATA_W-1]} - {1'b0, divisor_ff};
   assign last_iter = (iter_ff == ntp_pkg::ITER_W'(ntp_pkg::DATA_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntp_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               state_in = saturate ? ntp_pkg::DIV_DONE : ntp_pkg::DIV_RUN;
            end
         end
         ntp_pkg::DIV_RUN: begin
            if (last_iter) begin
               state_in = ntp_pkg::DIV_DONE;
            end
         end
         ntp_pkg::DIV_DONE: state_in = ntp_pkg::DIV_IDLE;
         default:           state_in = ntp_pkg::DIV_IDLE;
      endcase
   end

   // datapath: remainder and quotient shift together
   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      iter_in    = iter_ff;
      unique case (state_ff)
         ntp_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               divisor_in = div_req.divisor;
               iter_in    = '0;
               rem_in     = high_part;
               if (saturate) begin
                  quo_in = '1;
               end else begin
                  quo_in = div_req.dividend[ntp_pkg::DATA_W-1:0];
               end
            end
         end
         ntp_pkg::DIV_RUN: begin
            iter_in = iter_ff + ntp_pkg::ITER_W'(1);
            if (!trial[ntp_pkg::DATA_W]) begin
               rem_in = trial[ntp_pkg::DATA_W-1:0];
               quo_in = {quo_ff[ntp_pkg::DATA_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[ntp_pkg::DATA_W-2:0], quo_ff[ntp_pkg::DATA_W-1]};
               quo_in = {quo_ff[ntp_pkg::DATA_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntp_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      iter_ff    <= iter_in;
   end

   // response
   assign div_rsp.done     = (state_ff == ntp_pkg::DIV_DONE);
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/nested_task_time_profiler_unit.sv
// nested_task_time_profiler_unit: top level, request sequencer, task counters,
// preemption stack and result register; uses ntp_pkg and ntp_divider
//
// every request passes through dispatch and ends in the response state; a load read with
// nonzero elapsed time also waits for the divider, and a loop tick visits each task in turn
// throughput: one word at a time, req_stall high from acceptance until the result
// is handed to the result register, next word can be taken in the cycle rsp_valid rises
// reset: synchronous, clears counters, stack count, running flags and valids
`default_nettype none

module nested_task_time_profiler_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [2:0]                 req_type,
   input  wire logic [ntp_pkg::TASK_W-1:0] req_task_req,
   input  wire logic [ntp_pkg::DATA_W-1:0] req_timer_now,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [ntp_pkg::DATA_W-1:0] rsp_value,
   output      logic [1:0]                 rsp_status
);

   ntp_pkg::top_state_type state_ff, state_in;

   // request word
   ntp_pkg::req_code_type       type_ff, type_in;
   logic [ntp_pkg::TASK_W-1:0]  task_ff, task_in;
   logic [ntp_pkg::DATA_W-1:0]  now_ff, now_in;

   // working registers
   logic [ntp_pkg::TASK_W-1:0]  sel_ff, sel_in;
   logic [ntp_pkg::DATA_W-1:0]  diff_ff, diff_in;
   logic [ntp_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [ntp_pkg::DATA_W-1:0]  res_value_ff, res_value_in;
   ntp_pkg::status_type         res_status_ff, res_status_in;

   // preemption stack
   logic [ntp_pkg::TASK_W-1:0]  stack_ff [ntp_pkg::STACK_DEPTH];
   logic [ntp_pkg::TASK_W-1:0]  stack_in [ntp_pkg::STACK_DEPTH];
   logic [ntp_pkg::COUNT_W-1:0] count_ff, count_in;

   // per-task counters
   logic [ntp_pkg::DATA_W-1:0]  start_ff   [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  start_in   [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  current_ff [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  current_in [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  total_ff   [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  total_in   [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  loop_ff    [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  loop_in    [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  max_ff     [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  max_in     [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  last_ff    [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  last_in    [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::NUM_TASKS-1:0] running_ff, running_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ntp_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;

   // helpers
   logic [ntp_pkg::COUNT_W-1:0]     count_dec;
   logic [ntp_pkg::STACK_IDX_W-1:0] top_idx;
   logic [ntp_pkg::STACK_IDX_W-1:0] push_idx;
   logic                            task_ok;
   logic                            stack_full;
   logic                            stack_empty;
   logic                            rsp_free;
   logic [ntp_pkg::DATA_W-1:0]      sub_opnd;
   logic [ntp_pkg::DATA_W-1:0]      diff_calc;

   ntp_pkg::div_req_type div_req;
   ntp_pkg::div_rsp_type div_rsp;

   assign count_dec   = count_ff - ntp_pkg::COUNT_W'(1);
   assign top_idx     = count_dec[ntp_pkg::STACK_IDX_W-1:0];
   assign push_idx    = count_ff[ntp_pkg::STACK_IDX_W-1:0];
   assign task_ok     = (ntp_pkg::CMP_W'(task_ff) < ntp_pkg::CMP_W'(ntp_pkg::NUM_TASKS));
   assign stack_full  = (count_ff == ntp_pkg::COUNT_W'(ntp_pkg::STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // shared subtractor: elapsed time since start or since last load read
   assign sub_opnd  = (state_ff == ntp_pkg::S_LOAD_CALC) ? last_ff[sel_ff] : start_ff[sel_ff];
   assign diff_calc = now_ff - sub_opnd;

   // load division
   ntp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntp_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ntp_pkg::S_DISPATCH;
            end
         end
         ntp_pkg::S_DISPATCH: begin
            if (type_ff == ntp_pkg::REQ_TICK) begin
               state_in = ntp_pkg::S_TICK;
            end else if (!task_ok) begin
               state_in = ntp_pkg::S_RESP;
            end else begin
               unique case (type_ff)
                  ntp_pkg::REQ_BEGIN: begin
                     if (stack_full) begin
                        state_in = ntp_pkg::S_RESP;
                     end else if (!stack_empty) begin
                        state_in = ntp_pkg::S_CHG_DIFF;
                     end else begin
                        state_in = ntp_pkg::S_PUSH;
                     end
                  end
                  ntp_pkg::REQ_END: begin
                     state_in = stack_empty ? ntp_pkg::S_RESP : ntp_pkg::S_CHG_DIFF;
                  end
                  ntp_pkg::REQ_READ_LOAD: state_in = ntp_pkg::S_LOAD_CALC;
                  ntp_pkg::REQ_READ_MAX:  state_in = ntp_pkg::S_MAX_RD;
                  ntp_pkg::REQ_READ_ONGOING: begin
                     state_in = running_ff[task_ff] ? ntp_pkg::S_CHG_DIFF : ntp_pkg::S_RESP;
                  end
                  default: state_in = ntp_pkg::S_RESP;
               endcase
            end
         end
         ntp_pkg::S_CHG_DIFF: begin
            state_in = (type_ff == ntp_pkg::REQ_READ_ONGOING) ? ntp_pkg::S_ONG_SUM
                                                              : ntp_pkg::S_CHG_ADD;
         end
         ntp_pkg::S_CHG_ADD: begin
            state_in = (type_ff == ntp_pkg::REQ_BEGIN) ? ntp_pkg::S_PUSH : ntp_pkg::S_END_LOOP;
         end
         ntp_pkg::S_PUSH:     state_in = ntp_pkg::S_RESP;
         ntp_pkg::S_END_LOOP: begin
            state_in = stack_empty ? ntp_pkg::S_RESP : ntp_pkg::S_END_RESTART;
         end
         ntp_pkg::S_END_RESTART: state_in = ntp_pkg::S_RESP;
         ntp_pkg::S_ONG_SUM:     state_in = ntp_pkg::S_RESP;
         ntp_pkg::S_MAX_RD:      state_in = ntp_pkg::S_RESP;
         ntp_pkg::S_LOAD_CALC:   state_in = ntp_pkg::S_LOAD_CHECK;
         ntp_pkg::S_LOAD_CHECK: begin
            state_in = (diff_ff == '0) ? ntp_pkg::S_RESP : ntp_pkg::S_LOAD_WAIT;
         end
         ntp_pkg::S_LOAD_WAIT: begin
            if (div_rsp.done) begin
               state_in = ntp_pkg::S_RESP;
            end
         end
         ntp_pkg::S_TICK: begin
            if (sel_ff == ntp_pkg::TASK_W'(ntp_pkg::NUM_TASKS - 1)) begin
               state_in = ntp_pkg::S_RESP;
            end
         end
         ntp_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = ntp_pkg::S_IDLE;
            end
         end
         default: state_in = ntp_pkg::S_IDLE;
      endcase
   end

   // datapath and register updates per state
   always_comb begin
      type_in       = type_ff;
      task_in       = task_ff;
      now_in        = now_ff;
      sel_in        = sel_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      stack_in      = stack_ff;
      count_in      = count_ff;
      start_in      = start_ff;
      current_in    = current_ff;
      total_in      = total_ff;
      loop_in       = loop_ff;
      max_in        = max_ff;
      last_in       = last_ff;
      running_in    = running_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = diff_ff;

      // result register empties when taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ntp_pkg::S_IDLE: begin
            if (req_valid) begin
               type_in = ntp_pkg::req_code_type'(req_type);
               task_in = req_task_req;
               now_in  = req_timer_now;
            end
         end
         ntp_pkg::S_DISPATCH: begin
            res_value_in  = '0;
            res_status_in = ntp_pkg::STAT_OK;
            sel_in        = task_ff;
            if (type_ff == ntp_pkg::REQ_TICK) begin
               sel_in = '0;
            end else if (task_ok) begin
               if (type_ff == ntp_pkg::REQ_BEGIN) begin
                  if (stack_full) begin
                     res_status_in = ntp_pkg::STAT_OVERFLOW;
                  end else if (!stack_empty) begin
                     sel_in = stack_ff[top_idx];
                  end
               end else if (type_ff == ntp_pkg::REQ_END) begin
                  if (stack_empty) begin
                     res_status_in = ntp_pkg::STAT_UNDERFLOW;
                  end else begin
                     running_in[task_ff] = 1'b0;
                  end
               end
            end
         end
         ntp_pkg::S_CHG_DIFF: begin
            diff_in = diff_calc;
         end
         ntp_pkg::S_CHG_ADD: begin
            total_in[sel_ff]   = total_ff[sel_ff] + diff_ff;
            current_in[sel_ff] = current_ff[sel_ff] + diff_ff;
            if (type_ff == ntp_pkg::REQ_BEGIN) begin
               sel_in = task_ff;
            end else begin
               count_in = count_dec;
            end
         end
         ntp_pkg::S_PUSH: begin
            stack_in[push_idx] = task_ff;
            count_in           = count_ff + ntp_pkg::COUNT_W'(1);
            start_in[sel_ff]   = now_ff;
            current_in[sel_ff] = '0;
            running_in[sel_ff] = 1'b1;
         end
         ntp_pkg::S_END_LOOP: begin
            // fold this run into the per-loop time, then look at the paused task
            loop_in[sel_ff] = loop_ff[sel_ff] + current_ff[sel_ff];
            sel_in          = stack_ff[top_idx];
         end
         ntp_pkg::S_END_RESTART: begin
            start_in[sel_ff] = now_ff;
         end
         ntp_pkg::S_ONG_SUM: begin
            res_value_in = diff_ff + current_ff[sel_ff];
         end
         ntp_pkg::S_MAX_RD: begin
            res_value_in   = max_ff[sel_ff];
            max_in[sel_ff] = '0;
         end
         ntp_pkg::S_LOAD_CALC: begin
            diff_in          = diff_calc;
            prod_in          = ntp_pkg::PROD_W'(total_ff[sel_ff]) *
                               ntp_pkg::PROD_W'(ntp_pkg::PPM_SCALE);
            total_in[sel_ff] = '0;
            last_in[sel_ff]  = now_ff;
         end
         ntp_pkg::S_LOAD_CHECK: begin
            if (diff_ff == '0) begin
               res_value_in  = '1;
               res_status_in = ntp_pkg::STAT_ZERO_ELAPSED;
            end else begin
               div_req.start = 1'b1;
            end
         end
         ntp_pkg::S_LOAD_WAIT: begin
            if (div_rsp.done) begin
               res_value_in = div_rsp.quotient;
            end
         end
         ntp_pkg::S_TICK: begin
            // one task per cycle
            if (loop_ff[sel_ff] > max_ff[sel_ff]) begin
               max_in[sel_ff] = loop_ff[sel_ff];
            end
            loop_in[sel_ff] = '0;
            sel_in          = sel_ff + ntp_pkg::TASK_W'(1);
         end
         ntp_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntp_pkg::S_IDLE;
         count_ff     <= '0;
         start_ff     <= '{default: '0};
         current_ff   <= '{default: '0};
         total_ff     <= '{default: '0};
         loop_ff      <= '{default: '0};
         max_ff       <= '{default: '0};
         last_ff      <= '{default: '0};
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         current_ff   <= current_in;
         total_ff     <= total_in;
         loop_ff      <= loop_in;
         max_ff       <= max_in;
         last_ff      <= last_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff       <= type_in;
      task_ff       <= task_in;
      now_ff        <= now_in;
      sel_ff        <= sel_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      stack_ff      <= stack_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ports
   assign req_stall  = (state_ff != ntp_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ntp_pkg::COUNT_W'(ntp_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ntp_pkg::S_DISPATCH))
      else $error("accepted word not dispatched");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ntp_pkg::S_LOAD_WAIT))
      else $error("divider finished outside load read");

   a_zero_elapsed_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ntp_pkg::STAT_ZERO_ELAPSED) |-> (rsp_value == '1))
      else $error("zero elapsed result not saturated");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for nested_task_time_profiler_unit, a directed table
// then random nested traffic of all request codes, checked word by word against a
// local profiler model; depends on ntp_pkg and nested_task_time_profiler_unit
`default_nettype none

module testbench;

   // request codes the block leaves unused
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   localparam int PHASE_WORDS   = 275;
   localparam int DRAIN_CYCLES  = 60;
   localparam int WATCHDOG_IDLE = 4000;
   localparam int PLAN_ROWS     = 28;

   typedef struct {
      logic [ntp_pkg::DATA_W-1:0] value;
      ntp_pkg::status_type        status;
   } reading_type;

   typedef struct {
      logic [2:0]                 kind;
      logic [ntp_pkg::TASK_W-1:0] slot;
      logic [ntp_pkg::DATA_W-1:0] stamp;
      bit                         pinned;
      logic [ntp_pkg::DATA_W-1:0] value;
      ntp_pkg::status_type        status;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_type = 3'd0;
   logic [ntp_pkg::TASK_W-1:0] req_task_req = '0;
   logic [ntp_pkg::DATA_W-1:0] req_timer_now = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ntp_pkg::DATA_W-1:0] rsp_value;
   logic [1:0] rsp_status;

   // profiler state as the bench sees it
   logic [ntp_pkg::TASK_W-1:0]  held [ntp_pkg::STACK_DEPTH];
   logic [ntp_pkg::COUNT_W-1:0] stack_depth;
   logic [ntp_pkg::DATA_W-1:0]  run_start [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  run_accum [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  busy_sum [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  frame_sum [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  frame_peak [ntp_pkg::NUM_TASKS];
   logic [ntp_pkg::DATA_W-1:0]  load_mark [ntp_pkg::NUM_TASKS];
   bit                          is_running [ntp_pkg::NUM_TASKS];

   reading_type  readings_due [$];
   plan_row_type plan [PLAN_ROWS];
   reading_type  pin_reading;
   bit           pin_active = 1'b0;
   int           fail_count = 0;
   int           gap_pct = 0;
   int           stall_pct = 0;
   int           quiet_cycles = 0;

   nested_task_time_profiler_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_task_req  (req_task_req),
      .req_timer_now (req_timer_now),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // charge a task the time since its start
   function automatic void charge_task(input logic [ntp_pkg::TASK_W-1:0] t,
                                       input logic [ntp_pkg::DATA_W-1:0] now);
      logic [ntp_pkg::DATA_W-1:0] d;
      d = now - run_start[t];
      busy_sum[t] = busy_sum[t] + d;
      run_accum[t] = run_accum[t] + d;
   endfunction

   // advance the profiler state by one request and return its reading
   function automatic reading_type profile_step(input logic [2:0] kind,
                                                input logic [ntp_pkg::TASK_W-1:0] slot,
                                                input logic [ntp_pkg::DATA_W-1:0] now);
      reading_type r;
      logic [ntp_pkg::DATA_W-1:0] elapsed;
      logic [63:0] quot;
      r.value = '0;
      r.status = ntp_pkg::STAT_OK;
      if (kind == ntp_pkg::REQ_TICK) begin
         for (int i = 0; i < ntp_pkg::NUM_TASKS; i++) begin
            if (frame_sum[i] > frame_peak[i]) frame_peak[i] = frame_sum[i];
            frame_sum[i] = '0;
         end
      end else if (kind <= ntp_pkg::REQ_READ_ONGOING && slot < ntp_pkg::NUM_TASKS) begin
         case (kind)
            ntp_pkg::REQ_BEGIN: begin
               if (stack_depth == ntp_pkg::STACK_DEPTH) begin
                  r.status = ntp_pkg::STAT_OVERFLOW;
               end else begin
                  if (stack_depth != 0) charge_task(held[stack_depth - 1], now);
                  held[stack_depth] = slot;
                  stack_depth = stack_depth + 1'b1;
                  run_start[slot] = now;
                  run_accum[slot] = '0;
                  is_running[slot] = 1'b1;
               end
            end
            ntp_pkg::REQ_END: begin
               if (stack_depth == 0) begin
                  r.status = ntp_pkg::STAT_UNDERFLOW;
               end else begin
                  is_running[slot] = 1'b0;
                  charge_task(slot, now);
                  stack_depth = stack_depth - 1'b1;
                  // the paused task restarts from now
                  if (stack_depth != 0) run_start[held[stack_depth - 1]] = now;
                  frame_sum[slot] = frame_sum[slot] + run_accum[slot];
               end
            end
            ntp_pkg::REQ_READ_LOAD: begin
               elapsed = now - load_mark[slot];
               quot = ({32'd0, busy_sum[slot]} * 64'd1000000);
               busy_sum[slot] = '0;
               load_mark[slot] = now;
               if (elapsed == 0) begin
                  r.value = '1;
                  r.status = ntp_pkg::STAT_ZERO_ELAPSED;
               end else begin
                  quot = quot / {32'd0, elapsed};
                  r.value = (quot > 64'hFFFF_FFFF) ? '1 : quot[ntp_pkg::DATA_W-1:0];
               end
            end
            ntp_pkg::REQ_READ_MAX: begin
               r.value = frame_peak[slot];
               frame_peak[slot] = '0;
            end
            default: begin
               if (is_running[slot]) r.value = now - run_start[slot] + run_accum[slot];
            end
         endcase
      end
      return r;
   endfunction

   // present one word, with random idle cycles ahead of it
   task automatic send_word(input logic [2:0] kind, input logic [ntp_pkg::TASK_W-1:0] slot,
                            input logic [ntp_pkg::DATA_W-1:0] stamp, input bit pin,
                            input reading_type pinned);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_task_req <= slot;
      req_timer_now <= stamp;
      pin_active = pin;
      pin_reading = pinned;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // hold the sender off until every reading has come back
   task automatic drain_readings;
      req_valid <= 1'b0;
      @(negedge clock);
      while (readings_due.size() != 0) @(negedge clock);
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // predict accepted requests and check returned words in order
   always @(posedge clock) begin : result_check
      reading_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = profile_step(req_type, req_task_req, req_timer_now);
            if (pin_active) want = pin_reading;
            readings_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, got value %h status %0d",
                        $realtime, rsp_value, rsp_status);
               fail_count++;
            end else begin
               want = readings_due.pop_front();
               if (rsp_value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, got %h",
                           $realtime, want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $realtime, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_IDLE) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      reading_type                none;
      reading_type                pinned;
      logic [2:0]                 kind;
      logic [ntp_pkg::TASK_W-1:0] slot;
      logic [ntp_pkg::DATA_W-1:0] stamp;
      logic [ntp_pkg::DATA_W-1:0] timer_clock;
      int                         pick;
      int                         step;

      none.value = '0;
      none.status = ntp_pkg::STAT_OK;
      stack_depth = '0;
      for (int i = 0; i < ntp_pkg::STACK_DEPTH; i++) held[i] = '0;
      for (int i = 0; i < ntp_pkg::NUM_TASKS; i++) begin
         run_start[i] = '0;
         run_accum[i] = '0;
         busy_sum[i] = '0;
         frame_sum[i] = '0;
         frame_peak[i] = '0;
         load_mark[i] = '0;
         is_running[i] = 1'b0;
      end

      // directed table
      plan[0] = '{ntp_pkg::REQ_READ_LOAD, 2'd0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF,
                  ntp_pkg::STAT_ZERO_ELAPSED};
      plan[1] = '{ntp_pkg::REQ_END, 2'd1, 32'h0000_000A, 1'b1, 32'h0,
                  ntp_pkg::STAT_UNDERFLOW};
      plan[2] = '{ntp_pkg::REQ_READ_MAX, 2'd3, 32'h0000_0014, 1'b1, 32'h0, ntp_pkg::STAT_OK};
      plan[3] = '{ntp_pkg::REQ_READ_ONGOING, 2'd2, 32'h0000_001E, 1'b1, 32'h0,
                  ntp_pkg::STAT_OK};
      plan[4] = '{REQ_SPARE_6, 2'd1, 32'hFFFF_FFFF, 1'b1, 32'h0, ntp_pkg::STAT_OK};
      plan[5] = '{REQ_SPARE_7, 2'd2, 32'h5555_AAAA, 1'b1, 32'h0, ntp_pkg::STAT_OK};
      plan[6] = '{ntp_pkg::REQ_BEGIN, 2'd0, 32'hFFFF_0000, 1'b1, 32'h0, ntp_pkg::STAT_OK};
      // timer wraps while task 0 runs, then task 1 pauses it
      plan[7] = '{ntp_pkg::REQ_BEGIN, 2'd1, 32'h0000_0100, 1'b1, 32'h0, ntp_pkg::STAT_OK};
      // huge busy time over one tick saturates the load
      plan[8] = '{ntp_pkg::REQ_READ_LOAD, 2'd0, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF,
                  ntp_pkg::STAT_OK};
      // ongoing read of a paused task with a stale start
      plan[9] = '{ntp_pkg::REQ_READ_ONGOING, 2'd0, 32'h0000_0200, 1'b0, 32'h0,
                  ntp_pkg::STAT_OK};
      // fill the preemption stack
      for (int k = 0; k < ntp_pkg::STACK_DEPTH - 2; k++)
         plan[10 + k] = '{ntp_pkg::REQ_BEGIN, ntp_pkg::TASK_W'(k + 2),
                          32'h300 + 32'h100 * k, 1'b1, 32'h0, ntp_pkg::STAT_OK};
      plan[24] = '{ntp_pkg::REQ_BEGIN, 2'd3, 32'h0000_2000, 1'b1, 32'h0,
                   ntp_pkg::STAT_OVERFLOW};
      // end of a task that is not on top
      plan[25] = '{ntp_pkg::REQ_END, 2'd0, 32'h0000_2400, 1'b0, 32'h0, ntp_pkg::STAT_OK};
      plan[26] = '{ntp_pkg::REQ_TICK, 2'd2, 32'h0000_2500, 1'b0, 32'h0, ntp_pkg::STAT_OK};
      plan[27] = '{ntp_pkg::REQ_READ_MAX, 2'd0, 32'h0000_2600, 1'b0, 32'h0,
                   ntp_pkg::STAT_OK};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < PLAN_ROWS; r++) begin
         pinned.value = plan[r].value;
         pinned.status = plan[r].status;
         send_word(plan[r].kind, plan[r].slot, plan[r].stamp, plan[r].pinned, pinned);
      end
      drain_readings();

      // random nested traffic under four idling regimes
      timer_clock = 32'h0000_3000;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 63;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 63;
            end
            default: begin
               gap_pct = 38;
               stall_pct = 38;
            end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            slot = ntp_pkg::TASK_W'($urandom_range(ntp_pkg::NUM_TASKS - 1));
            step = $urandom_range(9);
            if (step == 1) timer_clock = timer_clock + $urandom;
            else if (step != 0) timer_clock = timer_clock + $urandom_range(1, 400);
            stamp = timer_clock;
            if (pick < 6) begin
               // noise: any code, any timer
               kind = 3'($urandom_range(7));
               stamp = $urandom;
            end else if (pick < 38) begin
               kind = ntp_pkg::REQ_BEGIN;
            end else if (pick < 70) begin
               kind = ntp_pkg::REQ_END;
               if (stack_depth != 0 && $urandom_range(9) != 0) slot = held[stack_depth - 1];
            end else if (pick < 78) begin
               kind = ntp_pkg::REQ_TICK;
            end else if (pick < 86) begin
               kind = ntp_pkg::REQ_READ_LOAD;
            end else if (pick < 93) begin
               kind = ntp_pkg::REQ_READ_MAX;
            end else begin
               kind = ntp_pkg::REQ_READ_ONGOING;
            end
            send_word(kind, slot, stamp, 1'b0, none);
         end
         drain_readings();
      end

      gap_pct = 0;
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && readings_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
